// File: hw/rtl/cpc_pkg.sv
package cpc_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAIR  = 2'd0,
    KIND_CODED = 2'd1,
    KIND_LANG  = 2'd2
  } kind_t;

  // coded write sets
  typedef enum logic [3:0] {
    SET_TOGGLE    = 4'd0,
    SET_SPECIAL   = 4'd1,
    SET_EXT_SP    = 4'd2,
    SET_EXT_PT    = 4'd3,
    SET_UNDERLINE = 4'd13,
    SET_ITALIC    = 4'd14,
    SET_CONTROL   = 4'd15
  } code_set_t;

  // input opcodes
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // control command values
  localparam logic [6:0] CTRL_BKSP   = 7'd0;
  localparam logic [6:0] CTRL_ERASE  = 7'd1;
  localparam logic [6:0] CTRL_RESUME = 7'd2;
  localparam logic [6:0] CTRL_START  = 7'd3;
  localparam logic [6:0] CTRL_END    = 7'd4;

  // high byte codes, channel bit masked off
  localparam logic [6:0] HI_MIDROW = 7'h11;
  localparam logic [6:0] HI_EXT_SP = 7'h12;
  localparam logic [6:0] HI_EXT_PT = 7'h13;
  localparam logic [6:0] HI_MISC_A = 7'h14;
  localparam logic [6:0] HI_MISC_B = 7'h15;
  localparam logic [6:0] HI_TAB    = 7'h17;
  localparam logic [6:0] HI_CHAN_MASK = 7'h77;
  localparam logic [6:0] HI_CTRL_MIN  = 7'h10;
  localparam logic [6:0] HI_PRINT_MIN = 7'h20;

  // low byte misc control codes
  localparam logic [6:0] LO_RCL = 7'h20;
  localparam logic [6:0] LO_BS  = 7'h21;
  localparam logic [6:0] LO_RU2 = 7'h25;
  localparam logic [6:0] LO_RU3 = 7'h26;
  localparam logic [6:0] LO_RU4 = 7'h27;
  localparam logic [6:0] LO_RDC = 7'h29;
  localparam logic [6:0] LO_TR  = 7'h2A;
  localparam logic [6:0] LO_RTD = 7'h2B;
  localparam logic [6:0] LO_CR  = 7'h2D;
  localparam logic [6:0] LO_ENM = 7'h2E;
  localparam logic [6:0] LO_EOC = 7'h2F;
  localparam logic [6:0] LO_TAB_UL = 7'h2E;

  localparam logic [6:0] CASE_BIT  = 7'h20;
  localparam logic [6:0] LETTER_X  = 7'h78;

  typedef struct packed {
    logic       opcode;
    logic [7:0] cc_type;
    logic [7:0] cc_hi;
    logic [7:0] cc_lo;
  } item_t;

  typedef struct packed {
    kind_t     kind;
    logic      chan;
    logic      track_sel;
    code_set_t code_set;
    logic [6:0] code_value;
    logic [6:0] char_first;
    logic [6:0] char_second;
    logic      lang_none;
    logic      last;
  } res_t;

  // language store update request
  typedef struct packed {
    logic        wr;
    logic        clr;
    logic [1:0]  slot;
    logic [13:0] tag;
  } lang_upd_t;

  function automatic logic is_letter(input logic [6:0] c);
    return ((c >= 7'h41) && (c <= 7'h5A)) || ((c >= 7'h61) && (c <= 7'h7A));
  endfunction

  function automatic res_t mk_coded(input logic ch, input logic trk,
                                    input code_set_t set, input logic [6:0] val);
    res_t r;
    r = '0;
    r.kind       = KIND_CODED;
    r.chan       = ch;
    r.track_sel  = trk;
    r.code_set   = set;
    r.code_value = val;
    return r;
  endfunction

endpackage

// File: hw/rtl/cpc_lang_store.sv
module cpc_lang_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [1:0]           rd_slot,
  input  cpc_pkg::lang_upd_t   upd,
  output logic [13:0]          rd_tag
);

  logic [13:0] tag [4];

  assign rd_tag = tag[rd_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) tag[i] <= '0;
    end else if (en) begin
      if (upd.clr) begin
        for (int i = 0; i < 4; i++) tag[i] <= '0;
      end else if (upd.wr) begin
        tag[upd.slot] <= upd.tag;
      end
    end
  end

endmodule

// File: hw/rtl/cpc_classify.sv
module cpc_classify (
  input  cpc_pkg::item_t     item,
  input  logic [13:0]        stored_tag,
  output cpc_pkg::lang_upd_t upd,
  output logic [1:0]         n_res,
  output cpc_pkg::res_t      res0,
  output cpc_pkg::res_t      res1
);

  logic [6:0] hi, lo, h, a, b;
  logic       ch, trk, italic;

  assign hi     = item.cc_hi[6:0];
  assign lo     = item.cc_lo[6:0];
  assign h      = hi & cpc_pkg::HI_CHAN_MASK;
  assign a      = hi | cpc_pkg::CASE_BIT;
  assign b      = lo | cpc_pkg::CASE_BIT;
  assign ch     = item.cc_type[0];
  assign trk    = hi[3];
  assign italic = (lo[3:1] == 3'b111);

  always_comb begin
    upd      = '0;
    upd.slot = {item.cc_hi[7], item.cc_lo[7]};
    upd.tag  = {a, b};
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;

    if (item.opcode == cpc_pkg::OP_CLEAR) begin
      upd.clr = 1'b1;
    end else if (item.cc_type == 8'd0 && cpc_pkg::is_letter(hi) &&
                 cpc_pkg::is_letter(lo)) begin
      // language tag, reported only on change
      if (stored_tag != {a, b}) begin
        upd.wr          = 1'b1;
        n_res           = 2'd1;
        res0.kind       = cpc_pkg::KIND_LANG;
        res0.chan       = upd.slot[1];
        res0.track_sel  = upd.slot[0];
        res0.char_first = a;
        res0.char_second = b;
        res0.lang_none  = (a == cpc_pkg::LETTER_X) && (b == cpc_pkg::LETTER_X);
      end
    end else if (item.cc_type[1] || hi < cpc_pkg::HI_CTRL_MIN) begin
      // field 2 types, empty pairs and xds: dropped
      n_res = 2'd0;
    end else if (hi >= cpc_pkg::HI_PRINT_MIN) begin
      n_res            = 2'd1;
      res0.kind        = cpc_pkg::KIND_PAIR;
      res0.chan        = ch;
      res0.char_first  = hi;
      res0.char_second = lo;
    end else if (lo[6]) begin
      // preamble: underline, then italic unless indent form
      n_res = 2'd1;
      res0  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_UNDERLINE, {6'd0, lo[0]});
      if (!lo[4]) begin
        n_res = 2'd2;
        res1  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_ITALIC, {6'd0, italic});
      end
    end else begin
      case (h)
        cpc_pkg::HI_MIDROW: begin
          if (lo[6:4] == 3'b011) begin
            n_res = 2'd1;
            res0  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_SPECIAL, {3'd0, lo[3:0]});
          end else if (lo[6:4] == 3'b010) begin
            n_res = 2'd2;
            res0  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_ITALIC, {6'd0, italic});
            res1  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_UNDERLINE, {6'd0, lo[0]});
          end
        end
        cpc_pkg::HI_EXT_SP, cpc_pkg::HI_EXT_PT: begin
          if (lo[6:5] == 2'b01) begin
            n_res = 2'd1;
            res0  = cpc_pkg::mk_coded(ch, trk,
                      h[0] ? cpc_pkg::SET_EXT_PT : cpc_pkg::SET_EXT_SP, {2'd0, lo[4:0]});
          end
        end
        cpc_pkg::HI_MISC_A, cpc_pkg::HI_MISC_B: begin
          n_res = 2'd1;
          case (lo)
            cpc_pkg::LO_RCL:
              res0 = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_CONTROL, cpc_pkg::CTRL_START);
            cpc_pkg::LO_BS:
              res0 = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_CONTROL, cpc_pkg::CTRL_BKSP);
            cpc_pkg::LO_RU2, cpc_pkg::LO_RU3, cpc_pkg::LO_RU4, cpc_pkg::LO_RDC,
            cpc_pkg::LO_EOC:
              res0 = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_CONTROL, cpc_pkg::CTRL_END);
            cpc_pkg::LO_TR, cpc_pkg::LO_RTD:
              res0 = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_CONTROL, cpc_pkg::CTRL_RESUME);
            cpc_pkg::LO_CR, cpc_pkg::LO_ENM:
              res0 = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_CONTROL, cpc_pkg::CTRL_ERASE);
            default: n_res = 2'd0;
          endcase
        end
        cpc_pkg::HI_TAB: begin
          if ((lo & 7'h7E) == cpc_pkg::LO_TAB_UL) begin
            n_res = 2'd1;
            res0  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_UNDERLINE, {6'd0, lo[0]});
          end
        end
        default: n_res = 2'd0;
      endcase
      // unrecognized control pair: toggle write
      if (n_res == 2'd0) begin
        n_res = 2'd1;
        res0  = cpc_pkg::mk_coded(ch, trk, cpc_pkg::SET_TOGGLE, 7'd0);
      end
    end

    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

endmodule

// File: hw/rtl/cpc_result_buf.sv
module cpc_result_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    n_req,
  input  logic          push,
  input  cpc_pkg::res_t res0,
  input  cpc_pkg::res_t res1,
  input  logic          pop,
  output logic          room,
  output logic          head_valid,
  output cpc_pkg::res_t head
);

  logic [1:0]    cnt, cnt_next, base;
  cpc_pkg::res_t e0, e1, e0_next, e1_next;

  assign base       = cnt - {1'b0, pop};
  assign room       = ({1'b0, base} + {1'b0, n_req}) <= 3'd2;
  assign head_valid = (cnt != 2'd0);
  assign head       = e0;

  always_comb begin
    e0_next  = e0;
    e1_next  = e1;
    cnt_next = base;
    if (pop) begin
      e0_next = e1;
    end
    if (push) begin
      cnt_next = base + n_req;
      case (base)
        2'd0: begin
          e0_next = res0;
          e1_next = res1;
        end
        2'd1: e1_next = res0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
    e0 <= e0_next;
    e1 <= e1_next;
  end

endmodule

// File: hw/rtl/cea608_pair_classifier.sv
// cea608_pair_classifier: classifies caption triplets into caption requests
//
// input channel: in_valid/in_stall carry one triplet request (opcode, cc_type,
//   cc_hi, cc_lo); it is taken at a rising edge with in_valid high and
//   in_stall low
// output channel: out_valid/out_stall carry result requests; an item yields
//   zero, one or two results and the last one of an item has last set
// path: the take edge loads the input register and, once the buffer has room,
//   a later edge moves the item's results into the result buffer, whose head
//   drives the output ports
// throughput: one item per cycle while each item gives at most one result and
//   the receiver takes them; items with two results are slowed to the pace
//   of the single result port draining the two-entry result buffer
// stall: a stalled result holds on the ports; once the buffer cannot take the
//   next item's results the input register holds and in_stall rises
// reset: rst (synchronous) empties the pipeline and clears the four stored
//   language tags; a clear opcode does the same to the tags without a result
module cea608_pair_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] cc_type,
  input  logic [7:0] cc_hi,
  input  logic [7:0] cc_lo,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic       chan,
  output logic       track_sel,
  output logic [3:0] code_set,
  output logic [6:0] code_value,
  output logic [6:0] char_first,
  output logic [6:0] char_second,
  output logic       lang_none,
  output logic       last
);

  // input register
  logic               s1_valid;
  cpc_pkg::item_t     s1_item;

  // classifier outputs
  cpc_pkg::lang_upd_t upd;
  logic [13:0]        stored_tag;
  logic [1:0]         rd_slot;
  logic [1:0]         n_res;
  cpc_pkg::res_t      res0, res1, head;

  logic               room, move, take, pop;

  // item leaves the input register when the buffer can hold all its results
  assign move     = s1_valid && room;
  assign in_stall = s1_valid && !room;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // slot of the held item, straight from the parity bits
  assign rd_slot  = {s1_item.cc_hi[7], s1_item.cc_lo[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_item <= '{opcode: opcode, cc_type: cc_type, cc_hi: cc_hi, cc_lo: cc_lo};
    end
  end

  // per-slot language tags, updated as the item moves on
  cpc_lang_store u_store (
    .clk     (clk),
    .rst     (rst),
    .en      (move),
    .rd_slot (rd_slot),
    .upd     (upd),
    .rd_tag  (stored_tag)
  );

  cpc_classify u_classify (
    .item       (s1_item),
    .stored_tag (stored_tag),
    .upd        (upd),
    .n_res      (n_res),
    .res0       (res0),
    .res1       (res1)
  );

  // two-entry result buffer parts the output from the input side
  cpc_result_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .n_req      (n_res),
    .push       (move),
    .res0       (res0),
    .res1       (res1),
    .pop        (pop),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign kind        = head.kind;
  assign chan        = head.chan;
  assign track_sel   = head.track_sel;
  assign code_set    = head.code_set;
  assign code_value  = head.code_value;
  assign char_first  = head.char_first;
  assign char_second = head.char_second;
  assign lang_none   = head.lang_none;
  assign last        = head.last;

endmodule

// File: hw/rtl/cpc_checker.sv
module cpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [3:0] code_set,
  input logic [6:0] code_value,
  input logic       lang_none,
  input logic       last
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(code_set)
      && $stable(code_value) && $stable(last))
    else $error("stalled result changed");

  // nothing shows right after reset
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // language and printable results always end their item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == cpc_pkg::KIND_LANG || kind == cpc_pkg::KIND_PAIR) |-> last)
    else $error("single result without last");

  // set and value are only used by coded writes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != cpc_pkg::KIND_CODED |-> code_set == 4'd0 && code_value == 7'd0)
    else $error("code fields set outside coded write");

  // no-language flag only on a language change
  assert property (@(posedge clk) disable iff (rst)
    out_valid && lang_none |-> kind == cpc_pkg::KIND_LANG)
    else $error("lang_none outside language result");

endmodule

bind cea608_pair_classifier cpc_checker u_cpc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .code_set   (code_set),
  .code_value (code_value),
  .lang_none  (lang_none),
  .last       (last)
);

// File: tb/sv/caption_result_checker.sv
module caption_result_checker
  import cpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       opcode,
  input  logic [7:0] cc_type,
  input  logic [7:0] cc_hi,
  input  logic [7:0] cc_lo,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic       chan,
  input  logic       track_sel,
  input  logic [3:0] code_set,
  input  logic [6:0] code_value,
  input  logic [6:0] char_first,
  input  logic [6:0] char_second,
  input  logic       lang_none,
  input  logic       last,
  output int         mismatches,
  output int         outstanding,
  output int         results_seen
);

  // language tag per slot, letter one over letter two
  logic [13:0] slot_tags [4];
  res_t        due_results [$];
  res_t        want;

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
    for (int i = 0; i < 4; i++) slot_tags[i] = '0;
  end

  function automatic bit letter7(input logic [6:0] c);
    return ((c >= 7'h41) && (c <= 7'h5A)) || ((c >= 7'h61) && (c <= 7'h7A));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
  endtask

  // works out the results of one triplet request and queues them
  task automatic classify_triplet(input logic op, input logic [7:0] typ,
                                  input logic [7:0] hi8, input logic [7:0] lo8);
    logic [6:0] hi, lo, a, b, h;
    logic [1:0] slot;
    res_t       base, r;
    res_t       batch [$];
    hi = hi8[6:0];
    lo = lo8[6:0];
    base = '0;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < 4; i++) slot_tags[i] = '0;
      return;
    end
    if (typ == 8'h00 && letter7(hi) && letter7(lo)) begin
      slot = {hi8[7], lo8[7]};
      a = hi | CASE_BIT;
      b = lo | CASE_BIT;
      if (slot_tags[slot] != {a, b}) begin
        slot_tags[slot] = {a, b};
        r = '0;
        r.kind = KIND_LANG;
        r.chan = slot[1];
        r.track_sel = slot[0];
        r.char_first = a;
        r.char_second = b;
        r.lang_none = (a == LETTER_X) && (b == LETTER_X);
        batch.push_back(r);
      end
    end else if (typ[1:0] <= 2'd1 && hi >= HI_CTRL_MIN) begin
      if (hi >= HI_PRINT_MIN) begin
        r = '0;
        r.kind = KIND_PAIR;
        r.chan = typ[0];
        r.char_first = hi;
        r.char_second = lo;
        batch.push_back(r);
      end else begin
        base.kind = KIND_CODED;
        base.chan = typ[0];
        base.track_sel = hi[3];
        h = hi & HI_CHAN_MASK;
        if (lo[6]) begin
          // preamble: underline, then italic unless bit 4 is set
          r = base;
          r.code_set = SET_UNDERLINE;
          r.code_value = {6'd0, lo[0]};
          batch.push_back(r);
          if (!lo[4]) begin
            r = base;
            r.code_set = SET_ITALIC;
            r.code_value = (lo[3:1] == 3'b111) ? 7'd1 : 7'd0;
            batch.push_back(r);
          end
        end else begin
          case (h)
            HI_MIDROW: begin
              if (lo[6:4] == 3'b011) begin
                r = base;
                r.code_set = SET_SPECIAL;
                r.code_value = {3'd0, lo[3:0]};
                batch.push_back(r);
              end else if (lo[6:4] == 3'b010) begin
                r = base;
                r.code_set = SET_ITALIC;
                r.code_value = (lo[3:1] == 3'b111) ? 7'd1 : 7'd0;
                batch.push_back(r);
                r.code_set = SET_UNDERLINE;
                r.code_value = {6'd0, lo[0]};
                batch.push_back(r);
              end
            end
            HI_EXT_SP, HI_EXT_PT: begin
              if (lo[6:5] == 2'b01) begin
                r = base;
                r.code_set = (h == HI_EXT_PT) ? SET_EXT_PT : SET_EXT_SP;
                r.code_value = {2'd0, lo[4:0]};
                batch.push_back(r);
              end
            end
            HI_MISC_A, HI_MISC_B: begin
              r = base;
              r.code_set = SET_CONTROL;
              case (lo)
                LO_RCL: begin
                  r.code_value = CTRL_START;
                  batch.push_back(r);
                end
                LO_BS: begin
                  r.code_value = CTRL_BKSP;
                  batch.push_back(r);
                end
                LO_RU2, LO_RU3, LO_RU4, LO_RDC, LO_EOC: begin
                  r.code_value = CTRL_END;
                  batch.push_back(r);
                end
                LO_TR, LO_RTD: begin
                  r.code_value = CTRL_RESUME;
                  batch.push_back(r);
                end
                LO_CR, LO_ENM: begin
                  r.code_value = CTRL_ERASE;
                  batch.push_back(r);
                end
                default: ;
              endcase
            end
            HI_TAB: begin
              if (lo[6:1] == LO_TAB_UL[6:1]) begin
                r = base;
                r.code_set = SET_UNDERLINE;
                r.code_value = {6'd0, lo[0]};
                batch.push_back(r);
              end
            end
            default: ;
          endcase
          // unrecognised control pair falls back to a toggle write
          if (batch.size() == 0) begin
            r = base;
            r.code_set = SET_TOGGLE;
            batch.push_back(r);
          end
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) slot_tags[i] = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0h chan %0h", kind, chan));
        end else begin
          want = due_results.pop_front();
          check_field("kind", 16'(kind), 16'(want.kind));
          check_field("chan", 16'(chan), 16'(want.chan));
          check_field("track_sel", 16'(track_sel), 16'(want.track_sel));
          check_field("code_set", 16'(code_set), 16'(want.code_set));
          check_field("code_value", 16'(code_value), 16'(want.code_value));
          check_field("char_first", 16'(char_first), 16'(want.char_first));
          check_field("char_second", 16'(char_second), 16'(want.char_second));
          check_field("lang_none", 16'(lang_none), 16'(want.lang_none));
          check_field("last", 16'(last), 16'(want.last));
        end
        results_seen++;
      end
      if (in_valid && !in_stall) classify_triplet(opcode, cc_type, cc_hi, cc_lo);
    end
    outstanding = due_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import cpc_pkg::*;

  // far above the slowest correct run: ~725 requests, each at most the largest
  // random gap plus two results that each wait out the largest random stall
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 700;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       opcode;
  logic [7:0] cc_type;
  logic [7:0] cc_hi;
  logic [7:0] cc_lo;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic       chan;
  logic       track_sel;
  logic [3:0] code_set;
  logic [6:0] code_value;
  logic [6:0] char_first;
  logic [6:0] char_second;
  logic       lang_none;
  logic       last;

  int mismatches;
  int outstanding;
  int results_seen;
  int cycle_count = 0;
  int requests_sent = 0;
  int clears_sent = 0;

  // when set, neither side idles: back-to-back traffic
  bit quiet = 1'b0;

  // misc control low bytes, all of them recognised codes
  logic [6:0] misc_lo [11] = '{LO_RCL, LO_BS, LO_RU2, LO_RU3, LO_RU4, LO_RDC,
                               LO_TR, LO_RTD, LO_CR, LO_ENM, LO_EOC};
  // small letter pool so tags repeat and the unchanged-tag path gets hit
  logic [6:0] tag_letters [6] = '{7'h45, 7'h4E, 7'h46, 7'h52, 7'h58, 7'h44};

  always #10 clk = ~clk;

  cea608_pair_classifier u_top (.*);

  caption_result_checker u_check (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // entered at a rising edge, returns at the edge that takes the request;
  // valid stays high across back-to-back requests, so it gets one write per step
  task automatic send_request(input logic op, input logic [7:0] typ,
                              input logic [7:0] hi8, input logic [7:0] lo8);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    cc_type <= typ;
    cc_hi <= hi8;
    cc_lo <= lo8;
    // stall is settled by the falling edge, so look there and take the next rise
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    requests_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // result side: random stall before each result, none in quiet stretches
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  initial begin
    int pick;
    logic op;
    logic [7:0] typ, hi8, lo8;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_DECODE;
    cc_type = 8'h00;
    cc_hi = 8'h00;
    cc_lo = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // language tags: first tag per slot, case folding, no-language, extremes
    send_request(OP_DECODE, 8'h00, 8'h45, 8'h4E);   // first tag in slot 0
    send_request(OP_DECODE, 8'h00, 8'h65, 8'h6E);   // same tag in lower case, no result
    send_request(OP_DECODE, 8'h00, 8'hF8, 8'hF8);   // slot 3 tagged as no language
    send_request(OP_DECODE, 8'h00, 8'h46, 8'hD2);   // slot 1
    send_request(OP_DECODE, 8'h00, 8'hDA, 8'h41);   // slot 2, letter range ends
    send_request(OP_DECODE, 8'h00, 8'hFA, 8'hE1);   // slot 3 changes away from none
    send_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);    // wipe all tags, no result
    send_request(OP_DECODE, 8'h00, 8'h45, 8'h4E);   // reported again after the wipe
    // dropped requests
    send_request(OP_DECODE, 8'h02, 8'h41, 8'h42);   // field type 2
    send_request(OP_DECODE, 8'hFF, 8'h7F, 8'h7F);   // field type 3
    send_request(OP_DECODE, 8'h01, 8'h80, 8'h41);   // empty pair after parity strip
    send_request(OP_DECODE, 8'h00, 8'h0F, 8'h01);   // xds code
    // printable pairs
    send_request(OP_DECODE, 8'h04, 8'h41, 8'h5B);   // a letter and a bracket, type byte not zero
    send_request(OP_DECODE, 8'hFD, 8'hFF, 8'hFF);   // top of range, channel 1
    send_request(OP_DECODE, 8'h00, 8'h20, 8'h00);   // bottom of range
    // coded writes
    send_request(OP_DECODE, 8'h01, 8'h11, 8'h4F);   // preamble, underline then italic
    send_request(OP_DECODE, 8'h00, 8'h19, 8'h71);   // preamble, underline only
    send_request(OP_DECODE, 8'h00, 8'h11, 8'h2F);   // mid-row, italic then underline
    send_request(OP_DECODE, 8'h01, 8'h19, 8'h37);   // special character
    send_request(OP_DECODE, 8'h00, 8'h12, 8'h3F);   // extended spanish/french
    send_request(OP_DECODE, 8'h00, 8'h1B, 8'h20);   // extended portuguese/german, track 1
    send_request(OP_DECODE, 8'h00, 8'h14, 8'h20);   // resume caption loading
    send_request(OP_DECODE, 8'h01, 8'h1D, 8'hAF);   // end of caption, parity bit set
    send_request(OP_DECODE, 8'h00, 8'h17, 8'h2F);   // tab-row underline
    send_request(OP_DECODE, 8'h00, 8'h10, 8'h00);   // unknown control, toggle write

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // every 50 requests decide whether this stretch runs without idling
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      op = OP_DECODE;
      typ = 8'($urandom);
      hi8 = 8'($urandom);
      lo8 = 8'($urandom);
      if (pick < 20) begin
        // language tag, random slot and case
        typ = 8'h00;
        hi8 = {hi8[7], tag_letters[$urandom_range(0, 5)] | (hi8[5] ? CASE_BIT : 7'h00)};
        lo8 = {lo8[7], tag_letters[$urandom_range(0, 5)] | (lo8[5] ? CASE_BIT : 7'h00)};
      end else if (pick < 23) begin
        op = OP_CLEAR;
      end else if (pick < 53) begin
        // control pair, half of them with a recognised misc low byte
        typ[1] = 1'b0;
        hi8 = {hi8[7], 3'b001, hi8[3:0]};
        if ($urandom_range(0, 1) == 1) lo8 = {lo8[7], misc_lo[$urandom_range(0, 10)]};
      end else if (pick < 73) begin
        // printable pair
        typ[1] = 1'b0;
        if (hi8[6:5] == 2'b00) hi8[5] = 1'b1;
      end
      // the rest is raw noise
      send_request(op, typ, hi8, lo8);
    end
    in_valid <= 1'b0;

    // drain, then give the two-stage pipe time to show anything stray
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d triplet requests (%0d tag clears) with random gaps and stalls",
             requests_sent, clears_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
